/* hw/rtl/hfps_pkg.sv */
package hfps_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;
    localparam int CNT_W    = 11;
    localparam int SAMP_W   = 32;
    localparam int COEF_W   = 18;
    localparam int DEPTH    = MAX_COLS + 2;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int DIFF_W   = SAMP_W + 3;
    localparam int PROD_W   = DIFF_W + COEF_W + 1;
    localparam int SUM_W    = PROD_W + 1;
    localparam int FRAC_W   = 18;

    typedef enum logic [1:0] {
        CFG_ROWS    = 2'd0,
        CFG_COLS    = 2'd1,
        CFG_COEFF_X = 2'd2,
        CFG_COEFF_Y = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
        logic             last;
    } t_meta;

    typedef struct packed {
        logic signed [SAMP_W-1:0] lf;
        logic signed [SAMP_W-1:0] up;
        logic signed [SAMP_W-1:0] ctr;
        logic signed [SAMP_W-1:0] rt;
        logic signed [SAMP_W-1:0] dn;
        t_meta                    meta;
    } t_win;

endpackage

/* hw/rtl/hfps_ram.sv */
module hfps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* hw/rtl/hfps_line_front.sv */
module hfps_line_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [hfps_pkg::CNT_W-1:0]  i_rows,
    input  logic [hfps_pkg::CNT_W-1:0]  i_cols,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [hfps_pkg::SAMP_W-1:0] i_sample,
    output logic                        o_win_valid,
    input  logic                        i_win_ready,
    output hfps_pkg::t_win              o_win
);
    import hfps_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic [CNT_W-1:0]  r_row;
    logic [CNT_W-1:0]  r_col;
    logic [CNT_W-1:0]  n_row;
    logic [CNT_W-1:0]  n_col;
    logic [CNT_W-1:0]  rows_p1;
    logic [CNT_W-1:0]  cols_p1;
    logic [CNT_W-1:0]  row_a;
    logic [CNT_W-1:0]  cur_row;
    logic [CNT_W-1:0]  cur_col;
    logic [CNT_W-1:0]  col_inc;
    logic [CNT_W-1:0]  row_inc;
    logic              col_wrap;
    logic              emit;
    logic              accept;
    logic              leave;

    logic              r_v1;
    logic              r_emit1;
    logic [SAMP_W-1:0] r_samp1;
    logic [SAMP_W-1:0] r_left;
    t_meta             r_meta1;

    logic [ADDR_W-1:0]   addr_a;
    logic [ADDR_W-1:0]   addr_b;
    logic [2*SAMP_W-1:0] rd_a;
    logic [2*SAMP_W-1:0] rd_b;

    assign rows_p1  = i_rows + CNT_W'(1);
    assign cols_p1  = i_cols + CNT_W'(1);
    assign col_wrap = r_col > cols_p1;
    assign row_a    = col_wrap ? r_row + CNT_W'(1) : r_row;
    assign cur_row  = (row_a > rows_p1) ? '0 : row_a;
    assign cur_col  = col_wrap ? '0 : r_col;
    assign col_inc  = cur_col + CNT_W'(1);
    assign row_inc  = cur_row + CNT_W'(1);
    assign emit     = (cur_row >= CNT_W'(2)) && (cur_col >= CNT_W'(1)) && (cur_col <= i_cols);

    always_comb begin
        if (col_inc > cols_p1) begin
            n_col = '0;
            n_row = (row_inc > rows_p1) ? '0 : row_inc;
        end else begin
            n_col = col_inc;
            n_row = cur_row;
        end
    end

    assign leave   = r_v1 && i_win_ready;
    assign o_ready = !r_v1 || i_win_ready;
    assign accept  = i_valid && o_ready;

    assign addr_a = cur_col[ADDR_W-1:0];
    assign addr_b = (addr_a == LAST_ADDR) ? addr_a : addr_a + ADDR_W'(1);

    hfps_ram #(
        .WIDTH (2 * SAMP_W),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_we      (leave),
        .i_waddr   (r_meta1.col[ADDR_W-1:0]),
        .i_wdata   ({rd_a[SAMP_W-1:0], r_samp1}),
        .i_re      (accept),
        .i_raddr_a (addr_a),
        .i_raddr_b (addr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_v1    <= 1'b0;
            r_left  <= '0;
        end else begin
            if (accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (o_ready) begin
                r_v1 <= i_valid;
            end
            if (leave) begin
                r_left <= rd_a[SAMP_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_emit1      <= emit;
            r_samp1      <= i_sample;
            r_meta1.row  <= cur_row - CNT_W'(1);
            r_meta1.col  <= cur_col;
            r_meta1.last <= (cur_row - CNT_W'(1) == i_rows) && (cur_col == i_cols);
        end
    end

    assign o_win_valid = r_v1 && r_emit1;

    always_comb begin
        o_win.lf   = r_left;
        o_win.up   = rd_a[2*SAMP_W-1:SAMP_W];
        o_win.ctr  = rd_a[SAMP_W-1:0];
        o_win.rt   = rd_b[SAMP_W-1:0];
        o_win.dn   = r_samp1;
        o_win.meta = r_meta1;
    end

endmodule

/* hw/rtl/hfps_arith.sv */
module hfps_arith (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [hfps_pkg::COEF_W-1:0] i_coeff_x,
    input  logic [hfps_pkg::COEF_W-1:0] i_coeff_y,
    input  logic                        i_win_valid,
    output logic                        o_win_ready,
    input  hfps_pkg::t_win              i_win,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hfps_pkg::SAMP_W-1:0] o_value,
    output hfps_pkg::t_meta             o_meta
);
    import hfps_pkg::*;

    localparam int V_W = SUM_W - FRAC_W + 1;
    localparam logic signed [V_W-1:0] SAT_HI = V_W'(64'sd2147483647);
    localparam logic signed [V_W-1:0] SAT_LO = -V_W'(64'sd2147483648);
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC_W - 1);

    logic ld_out;
    logic ld3;
    logic ld2;
    logic ld1;

    logic                     r_v1;
    logic                     r_v2;
    logic                     r_v3;
    logic                     r_ov;
    logic signed [DIFF_W-1:0] r_dv;
    logic signed [DIFF_W-1:0] r_dh;
    logic signed [SAMP_W-1:0] r_ctr1;
    logic signed [SAMP_W-1:0] r_ctr2;
    logic signed [SAMP_W-1:0] r_ctr3;
    t_meta                    r_meta1;
    t_meta                    r_meta2;
    t_meta                    r_meta3;
    logic signed [PROD_W-1:0] r_pv;
    logic signed [PROD_W-1:0] r_ph;
    logic signed [SUM_W-1:0]  r_sum;
    logic [SAMP_W-1:0]        r_value;
    t_meta                    r_meta_out;

    logic signed [DIFF_W-1:0]   dv;
    logic signed [DIFF_W-1:0]   dh;
    logic signed [V_W-2:0]      incr;
    logic signed [V_W-1:0]      v;
    logic [SAMP_W-1:0]          sat;

    assign ld_out      = !r_ov || i_ready;
    assign ld3         = !r_v3 || ld_out;
    assign ld2         = !r_v2 || ld3;
    assign ld1         = !r_v1 || ld2;
    assign o_win_ready = ld1;

    assign dv = DIFF_W'(i_win.up) + DIFF_W'(i_win.dn) - (DIFF_W'(i_win.ctr) <<< 1);
    assign dh = DIFF_W'(i_win.lf) + DIFF_W'(i_win.rt) - (DIFF_W'(i_win.ctr) <<< 1);

    assign incr = r_sum[SUM_W-1:FRAC_W];
    assign v    = V_W'(r_ctr3) + V_W'(incr);

    always_comb begin
        if (v > SAT_HI) begin
            sat = SAT_HI[SAMP_W-1:0];
        end else if (v < SAT_LO) begin
            sat = SAT_LO[SAMP_W-1:0];
        end else begin
            sat = v[SAMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (ld1) begin
                r_v1 <= i_win_valid;
            end
            if (ld2) begin
                r_v2 <= r_v1;
            end
            if (ld3) begin
                r_v3 <= r_v2;
            end
            if (ld_out) begin
                r_ov <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_dv    <= dv;
            r_dh    <= dh;
            r_ctr1  <= i_win.ctr;
            r_meta1 <= i_win.meta;
        end
        if (ld2) begin
            r_pv    <= PROD_W'(r_dv * $signed({1'b0, i_coeff_x}));
            r_ph    <= PROD_W'(r_dh * $signed({1'b0, i_coeff_y}));
            r_ctr2  <= r_ctr1;
            r_meta2 <= r_meta1;
        end
        if (ld3) begin
            r_sum   <= SUM_W'(r_pv) + SUM_W'(r_ph) + HALF;
            r_ctr3  <= r_ctr2;
            r_meta3 <= r_meta2;
        end
        if (ld_out) begin
            r_value    <= sat;
            r_meta_out <= r_meta3;
        end
    end

    assign o_valid = r_ov;
    assign o_value = r_value;
    assign o_meta  = r_meta_out;

endmodule

/* hw/rtl/heat_five_point_stencil.sv */
// Five-point heat-equation step on a grid streamed in raster order.
// The slave stream carries one signed Q16.16 sample per word, covering the
// whole grid with its one-cell halo: (rows + 2) lines of (cols + 2) samples.
// The master stream carries one word per interior point: tdata holds the
// saturated new value, the one-based row and the one-based column, and tlast
// marks the final interior point of the grid. Halo samples yield no word.
// Grid size and the two Q0.18 coefficients are set through the write port
// while the stream is idle; sizes of zero act as one, sizes above 1024 (the
// MAX_ROWS and MAX_COLS limit) act as 1024.
// A result is produced from the sample directly below its point. One sample
// is taken per cycle unless stalled; the figure is set by the single line
// store RAM, read at two columns and written back once for every sample.
// Reset clears the raster counters, the window and the pipeline and restores
// a one by one grid with zero coefficients; the line store is not cleared.
// When the receiver stalls, the word is held in the output register and the
// pipeline keeps taking samples until its stages are full, then tready drops.
module heat_five_point_stencil (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [31:0]                   i_s_axis_tdata,   // sample[31:0]
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // new_value[31:0], row_index[42:32], col_index[53:43], zero padding[55:54]
    output logic [55:0]                   o_m_axis_tdata,
    output logic                          o_m_axis_tlast,   // frame_last
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [hfps_pkg::COEF_W-1:0]   i_cfg_data
);
    import hfps_pkg::*;

    localparam logic [CNT_W-1:0] MAX_COLS_C = CNT_W'(MAX_COLS);
    localparam logic [CNT_W-1:0] MAX_ROWS_C = CNT_W'(MAX_ROWS);

    logic [CNT_W-1:0]  r_rows;
    logic [CNT_W-1:0]  r_cols;
    logic [COEF_W-1:0] r_coeff_x;
    logic [COEF_W-1:0] r_coeff_y;
    logic [CNT_W-1:0]  eff_rows;
    logic [CNT_W-1:0]  eff_cols;

    logic              win_valid;
    logic              win_ready;
    t_win              win;
    logic [SAMP_W-1:0] value;
    t_meta             meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows    <= CNT_W'(1);
            r_cols    <= CNT_W'(1);
            r_coeff_x <= '0;
            r_coeff_y <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ROWS:    r_rows    <= i_cfg_data[CNT_W-1:0];
                CFG_COLS:    r_cols    <= i_cfg_data[CNT_W-1:0];
                CFG_COEFF_X: r_coeff_x <= i_cfg_data;
                CFG_COEFF_Y: r_coeff_y <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        priority if (r_rows == '0) begin
            eff_rows = CNT_W'(1);
        end else if (r_rows > MAX_ROWS_C) begin
            eff_rows = MAX_ROWS_C;
        end else begin
            eff_rows = r_rows;
        end
        priority if (r_cols == '0) begin
            eff_cols = CNT_W'(1);
        end else if (r_cols > MAX_COLS_C) begin
            eff_cols = MAX_COLS_C;
        end else begin
            eff_cols = r_cols;
        end
    end

    hfps_line_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rows      (eff_rows),
        .i_cols      (eff_cols),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_sample    (i_s_axis_tdata),
        .o_win_valid (win_valid),
        .i_win_ready (win_ready),
        .o_win       (win)
    );

    hfps_arith u_arith (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_coeff_x   (r_coeff_x),
        .i_coeff_y   (r_coeff_y),
        .i_win_valid (win_valid),
        .o_win_ready (win_ready),
        .i_win       (win),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_value     (value),
        .o_meta      (meta)
    );

    assign o_m_axis_tdata = {2'b00, meta.col, meta.row, value};
    assign o_m_axis_tlast = meta.last;

endmodule

/* verif/tb_heat_five_point_stencil.sv */
import hfps_pkg::*;

typedef struct {
    logic [31:0] value;
    logic [10:0] row;
    logic [10:0] col;
    logic        last;
} stencil_result_t;

class stencil_scoreboard;
    int unsigned     rows;
    int unsigned     cols;
    longint          coeff_x;
    longint          coeff_y;
    logic [31:0]     line_above [DEPTH];
    logic [31:0]     line_above2 [DEPTH];
    logic [31:0]     left_word;
    int unsigned     row_pos;
    int unsigned     col_pos;
    stencil_result_t expected_results [$];
    int unsigned     samples_seen;
    int unsigned     results_checked;
    int unsigned     mismatches;

    function new();
        rows = 1;
        cols = 1;
        coeff_x = 0;
        coeff_y = 0;
        foreach (line_above[i]) begin
            line_above[i] = '0;
            line_above2[i] = '0;
        end
        left_word = '0;
        row_pos = 0;
        col_pos = 0;
        samples_seen = 0;
        results_checked = 0;
        mismatches = 0;
    endfunction

    function int unsigned eff_size(int unsigned v, int unsigned lim);
        if (v < 1) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function void note_config(t_cfg_idx idx, logic [COEF_W-1:0] data);
        case (idx)
            CFG_ROWS: begin
                rows = data[CNT_W-1:0];
            end
            CFG_COLS: begin
                cols = data[CNT_W-1:0];
            end
            CFG_COEFF_X: begin
                coeff_x = data;
            end
            CFG_COEFF_Y: begin
                coeff_y = data;
            end
            default: begin
            end
        endcase
    endfunction

    function logic [31:0] stencil_value(logic signed [31:0] lf, logic signed [31:0] up,
                                        logic signed [31:0] ctr, logic signed [31:0] rt,
                                        logic signed [31:0] dn);
        longint dv;
        longint dh;
        longint acc;
        longint v;
        dv = longint'(up) + longint'(dn) - 2 * longint'(ctr);
        dh = longint'(lf) + longint'(rt) - 2 * longint'(ctr);
        acc = dv * coeff_x + dh * coeff_y;
        // Round half up to Q16.16, then saturate.
        v = longint'(ctr) + ((acc + 64'sd131072) >>> 18);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function void note_sample(logic [31:0] s);
        int unsigned     r_lim;
        int unsigned     c_lim;
        int unsigned     r;
        int unsigned     c;
        logic [31:0]     above;
        logic [31:0]     right;
        stencil_result_t res;
        r_lim = eff_size(rows, MAX_ROWS);
        c_lim = eff_size(cols, MAX_COLS);
        samples_seen++;
        if (col_pos > c_lim + 1) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos > r_lim + 1) row_pos = 0;
        r = row_pos;
        c = col_pos;
        above = line_above[c];
        right = (c + 1 <= c_lim + 1) ? line_above[c + 1] : '0;
        if (r >= 2 && c >= 1 && c <= c_lim) begin
            res.value = stencil_value(left_word, line_above2[c], above, right, s);
            res.row = 11'(r - 1);
            res.col = 11'(c);
            res.last = (r - 1 == r_lim) && (c == c_lim);
            expected_results.push_back(res);
        end
        line_above2[c] = above;
        line_above[c] = s;
        left_word = above;
        col_pos = c + 1;
        if (col_pos > c_lim + 1) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos > r_lim + 1) row_pos = 0;
        end
    endfunction

    function int unsigned samples_to_grid_end();
        int unsigned h;
        int unsigned w;
        int unsigned r;
        int unsigned c;
        h = eff_size(rows, MAX_ROWS) + 2;
        w = eff_size(cols, MAX_COLS) + 2;
        r = row_pos;
        c = col_pos;
        if (c > w - 1) begin
            c = 0;
            r++;
        end
        if (r > h - 1) r = 0;
        return h * w - (r * w + c);
    endfunction

    function void check_result(logic [55:0] data, logic last);
        stencil_result_t want;
        if (expected_results.size() == 0) begin
            if (mismatches < 10) begin
                $display("unexpected word: value %h row %0d col %0d last %0b",
                         data[31:0], data[42:32], data[53:43], last);
            end
            mismatches++;
            return;
        end
        want = expected_results.pop_front();
        results_checked++;
        if (data[31:0] !== want.value || data[42:32] !== want.row ||
            data[53:43] !== want.col || last !== want.last) begin
            if (mismatches < 10) begin
                $display("mismatch: expected %h r%0d c%0d l%0b, got %h r%0d c%0d l%0b",
                         want.value, want.row, want.col, want.last,
                         data[31:0], data[42:32], data[53:43], last);
            end
            mismatches++;
        end
    endfunction
endclass

module tb_heat_five_point_stencil;
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [31:0]       s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [55:0]       m_data;
    logic              m_last;
    logic              cfg_we = 1'b0;
    logic [1:0]        cfg_index = CFG_ROWS;
    logic [COEF_W-1:0] cfg_data = '0;

    bit                quiet = 1'b0;
    int unsigned       src_idle_pct = 0;
    int unsigned       sink_stall_pct = 0;
    int unsigned       reg_writes = 0;

    stencil_scoreboard sb = new();

    heat_five_point_stencil u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        #4000000;
        $display("FAIL heat_five_point_stencil");
        $finish;
    end

    function automatic int unsigned pick_rate();
        case ($urandom_range(0, 4))
            0, 1: return 0;
            2: return 10;
            3: return 30;
            default: return 60;
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_size(input bit tall);
        int unsigned sz;
        case ($urandom_range(0, 19))
            0: sz = 0;
            1: sz = tall ? $urandom_range(1024, 2047) : $urandom_range(7, 40);
            2, 3, 4: sz = $urandom_range(7, 40);
            default: sz = $urandom_range(1, 6);
        endcase
        // Bits above the 11-bit register are noise and must be dropped.
        return {7'($urandom_range(0, 127)), 11'(sz)};
    endfunction

    function automatic logic [COEF_W-1:0] rand_coeff();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return COEF_W'($urandom_range(0, 4095));
            default: return COEF_W'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 32'($urandom_range(0, 32'h1F_FFFF)) - 32'h10_0000;
            4, 5, 6: return $urandom;
            7: return 32'h7FFF_FFFF;
            8: return 32'h8000_0000;
            default: return {($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000,
                             16'($urandom)};
        endcase
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [COEF_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.note_config(idx, data);
        reg_writes++;
        @(negedge clk);
    endtask

    task automatic send_sample(input logic [31:0] value);
        int unsigned gap;
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            gap = $urandom_range(1, 16);
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data <= value;
        do @(posedge clk); while (!s_ready);
        sb.note_sample(value);
        @(negedge clk);
    endtask

    task automatic send_random(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) send_sample(rand_sample());
    endtask

    // A 3x3 grid: the halo value everywhere except the centre and the word above it.
    task automatic send_cross(input logic [31:0] halo, input logic [31:0] centre,
                              input logic [31:0] up);
        for (int i = 0; i < 9; i++) begin
            send_sample((i == 4) ? centre : (i == 1) ? up : halo);
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic random_config();
        if ($urandom_range(0, 2) != 0) write_reg(CFG_ROWS, rand_size(1'b1));
        if ($urandom_range(0, 2) != 0) write_reg(CFG_COLS, rand_size(1'b0));
        if ($urandom_range(0, 2) != 0) write_reg(CFG_COEFF_X, rand_coeff());
        if ($urandom_range(0, 2) != 0) write_reg(CFG_COEFF_Y, rand_coeff());
    endtask

    initial begin
        int unsigned stall_left;
        int unsigned cycle_count;
        stall_left = 0;
        cycle_count = 0;
        forever begin
            @(negedge clk);
            cycle_count++;
            if (cycle_count % 200 == 0) sink_stall_pct = pick_rate();
            if (stall_left != 0) stall_left--;
            else if (!quiet && $urandom_range(0, 99) < sink_stall_pct) begin
                stall_left = $urandom_range(1, 16);
            end
            m_ready <= (stall_left == 0) || quiet;
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) sb.check_result(m_data, m_last);
    end

    initial begin
        int unsigned remaining;
        int unsigned burst;
        int unsigned random_sent;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_reg(CFG_ROWS, 18'h3F800);
        write_reg(CFG_COLS, '0);
        write_reg(CFG_COEFF_X, '1);
        write_reg(CFG_COEFF_Y, '1);
        send_cross(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_cross(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        settle();
        // With the smallest vertical coefficient this lands exactly on a half.
        write_reg(CFG_COEFF_X, 18'd1);
        write_reg(CFG_COEFF_Y, '0);
        send_cross(32'd0, 32'd0, 32'd131072);
        settle();

        // Widest grid of the run first, so that both line stores are filled
        // before any size change part-way through a grid.
        src_idle_pct = pick_rate();
        write_reg(CFG_ROWS, '0);
        write_reg(CFG_COLS, 18'd40);
        write_reg(CFG_COEFF_X, rand_coeff());
        write_reg(CFG_COEFF_Y, rand_coeff());
        send_random(sb.samples_to_grid_end());
        settle();
        src_idle_pct = pick_rate();
        write_reg(CFG_ROWS, 18'd60);
        write_reg(CFG_COLS, '0);
        send_random(sb.samples_to_grid_end());
        settle();

        random_sent = 0;
        while (random_sent < 1200) begin
            if (random_sent >= 1000) quiet = 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                settle();
                random_config();
            end
            src_idle_pct = quiet ? 0 : pick_rate();
            remaining = sb.samples_to_grid_end();
            if (remaining <= 200 && $urandom_range(0, 3) != 0) burst = remaining;
            else burst = $urandom_range(1, (remaining < 40) ? remaining : 40);
            send_random(burst);
            random_sent += burst;
        end
        settle();

        $display("Streamed %0d samples with %0d register writes, grids up to 40 wide.",
                 sb.samples_seen, reg_writes);
        $display("Checked %0d stencil results with %0d mismatches.",
                 sb.results_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("PASS heat_five_point_stencil");
        end else begin
            $display("FAIL heat_five_point_stencil");
        end
        $finish;
    end
endmodule

/* filelist.f */
hw/rtl/hfps_pkg.sv
hw/rtl/hfps_ram.sv
hw/rtl/hfps_line_front.sv
hw/rtl/hfps_arith.sv
hw/rtl/heat_five_point_stencil.sv
verif/tb_heat_five_point_stencil.sv
